// ===== rtl/upd_pkg.sv =====
`default_nettype none
package upd_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Pending escape state
    localparam logic [1:0] PEND_NONE    = 2'd0;
    localparam logic [1:0] PEND_PERCENT = 2'd1;
    localparam logic [1:0] PEND_DIGIT   = 2'd2;

    // One decoded group: up to three bytes, emitted from index 0 upward
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      count;
        logic            last;
    } cmd_t;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                 (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
            v = c - 8'h30;
        else if (c >= 8'h41 && c <= 8'h46)
            v = c - 8'h41 + 8'd10;
        else if (c >= 8'h61 && c <= 8'h66)
            v = c - 8'h61 + 8'd10;
        hex_value = v[3:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/upd_if.sv =====
`default_nettype none
interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/upd_front.sv =====
`default_nettype none
module upd_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    upd_in_if.sink            rx,
    output upd_pkg::cmd_t     cmd,
    output logic              push,
    input  wire logic         full
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic       accept;
    logic       hex;
    logic       do_plain;
    logic [1:0] n;
    logic [2:0][7:0] bytes;

    assign rx.ready = !full;
    assign accept   = rx.valid && !full;
    assign hex      = upd_pkg::is_hex(rx.in_byte);

    always_comb
    begin
        n         = 2'd0;
        bytes     = '0;
        pend_next = upd_pkg::PEND_NONE;
        held_next = held_reg;
        do_plain  = 1'b0;

        case (pend_reg)
            upd_pkg::PEND_PERCENT:
            begin
                if (hex)
                begin
                    pend_next = upd_pkg::PEND_DIGIT;
                    held_next = rx.in_byte;
                end
                else
                begin
                    bytes[n] = upd_pkg::CH_PERCENT;
                    n        = n + 2'd1;
                    do_plain = 1'b1;
                end
            end
            upd_pkg::PEND_DIGIT:
            begin
                held_next = 8'h00;
                if (hex)
                begin
                    bytes[n] = {upd_pkg::hex_value(held_reg), upd_pkg::hex_value(rx.in_byte)};
                    n        = n + 2'd1;
                end
                else
                begin
                    bytes[n] = upd_pkg::CH_PERCENT;
                    n        = n + 2'd1;
                    bytes[n] = held_reg;
                    n        = n + 2'd1;
                    do_plain = 1'b1;
                end
            end
            default:
            begin
                do_plain = 1'b1;
            end
        endcase

        if (do_plain)
        begin
            if (rx.in_byte == upd_pkg::CH_PLUS)
            begin
                bytes[n] = upd_pkg::CH_SPACE;
                n        = n + 2'd1;
            end
            else if (rx.in_byte == upd_pkg::CH_PERCENT)
            begin
                pend_next = upd_pkg::PEND_PERCENT;
            end
            else
            begin
                bytes[n] = rx.in_byte;
                n        = n + 2'd1;
            end
        end

        // Flush whatever is still held at end of string
        if (rx.in_last)
        begin
            if (pend_next == upd_pkg::PEND_PERCENT)
            begin
                bytes[n] = upd_pkg::CH_PERCENT;
                n        = n + 2'd1;
            end
            else if (pend_next == upd_pkg::PEND_DIGIT)
            begin
                bytes[n] = upd_pkg::CH_PERCENT;
                n        = n + 2'd1;
                bytes[n] = held_next;
                n        = n + 2'd1;
            end
            pend_next = upd_pkg::PEND_NONE;
            held_next = 8'h00;
        end
    end

    assign cmd.data  = bytes;
    assign cmd.count = n;
    assign cmd.last  = rx.in_last;
    assign push      = accept && (n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= upd_pkg::PEND_NONE;
            held_reg <= 8'h00;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            held_reg <= held_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/upd_queue.sv =====
`default_nettype none
module upd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire upd_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output upd_pkg::cmd_t      head,
    output logic               empty
);

    upd_pkg::cmd_t                  mem_reg [upd_pkg::QUEUE_DEPTH];
    logic [upd_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [upd_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [upd_pkg::QPTR_W:0]       fill_reg;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (fill_reg == (upd_pkg::QPTR_W+1)'(upd_pkg::QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/upd_back.sv =====
`default_nettype none
module upd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire upd_pkg::cmd_t head,
    input  wire logic          empty,
    output logic               pop,
    upd_out_if.source          tx
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       load;
    logic       final_byte;

    assign load       = !empty && (!valid_reg || tx.ready);
    assign final_byte = (idx_reg == head.count - 2'd1);
    assign pop        = load && final_byte;
    assign idx_next   = final_byte ? 2'd0 : idx_reg + 2'd1;

    assign tx.valid    = valid_reg;
    assign tx.out_byte = byte_reg;
    assign tx.out_last = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.data[idx_reg];
            last_reg <= head.last && final_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= idx_next;
            end
            else if (tx.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/url_percent_decoder_top.sv =====
// Form-urlencoded percent decoder.
// rx carries one raw byte per transaction (in_byte) with in_last marking the
// final byte of a string. tx carries decoded bytes (out_byte) with out_last on
// the final decoded byte of a string. Both channels transfer on valid && ready.
// A plus becomes a space; a percent sign plus two hex digits becomes one byte.
// Broken or truncated escapes pass through unchanged.
// Each rx transaction that yields bytes writes its group into the queue; the back
// end registers those bytes from the queue head into the output register.
// Throughput: one rx transaction per cycle while each yields at most one byte;
// a broken escape yields up to three bytes, drained at one tx byte per cycle
// while tx is ready, so rx stalls only once the four-entry group queue fills.
// The front end holds the escape state and classifies each byte into a group;
// the queue decouples it from the back end, which owns the output register.
// Reset clears the escape state, empties the queue and drops tx valid.
// When the receiver holds tx ready low, the output register holds its byte,
// the queue fills, and then rx ready drops until room frees up.
`default_nettype none
module url_percent_decoder_top (
    input  wire logic clk,
    input  wire logic rst_n,
    upd_in_if.sink    rx,
    upd_out_if.source tx
);

    upd_pkg::cmd_t cmd;
    upd_pkg::cmd_t head;
    logic          push;
    logic          full;
    logic          pop;
    logic          empty;

    // Classify each accepted byte and track the open escape
    upd_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .cmd   (cmd),
        .push  (push),
        .full  (full)
    );

    // Hold decoded groups between front and back
    upd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    // Emit group bytes one per cycle into the output register while it is free or tx is ready
    upd_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .tx    (tx)
    );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    localparam int RAW_ITEMS   = 460;
    // Cycles without any transaction on either side before the run is called hung
    localparam int STALL_LIMIT = 2000;
    // Cycles with no random idling on either side
    localparam int QUIET_FROM  = 200;
    localparam int QUIET_TO    = 450;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       drain_first;    // hold this byte back until all decoded bytes are out
    } raw_byte_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } decoded_byte_t;

    logic clk = 1'b0;
    logic rst_n;

    upd_in_if  rx();
    upd_out_if tx();

    url_percent_decoder_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .tx    (tx)
    );

    always #1 clk = ~clk;

    // Raw input bytes waiting to be sent, and decoded bytes waiting to arrive
    raw_byte_t     raw_q[$];
    decoded_byte_t decoded_q[$];

    int   errors = 0;
    int   cyc = 0;
    int   stall_cycles = 0;
    logic drained = 1'b1;

    // Escape state of the predictor
    logic [1:0] esc_state = upd_pkg::PEND_NONE;
    logic [7:0] esc_digit = 8'h00;

    always @(posedge clk)
        cyc <= cyc + 1;

    // Sample the drain condition away from the active edge so that the driver
    // sees a stable value no matter how the clocked blocks are ordered.
    always @(negedge clk)
        drained = (decoded_q.size() == 0);

    function automatic logic hex_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    // Digits keep their low nibble; both letter cases map 'A'/'a' (low nibble 1) to 10.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        return (c <= "9") ? c[3:0] : c[3:0] + 4'd9;
    endfunction

    // Decode one raw byte and queue the bytes it releases.
    task automatic decode_byte(input logic [7:0] b, input logic lst);
        logic [7:0]    outs[3];
        int            n;
        logic          as_plain;
        decoded_byte_t d;
        n = 0;
        as_plain = 1'b0;
        case (esc_state)
            upd_pkg::PEND_PERCENT:
                if (hex_char(b))
                begin
                    esc_digit = b;
                    esc_state = upd_pkg::PEND_DIGIT;
                end
                else
                begin
                    // Broken right after the percent sign: release it, then decode b
                    outs[n] = upd_pkg::CH_PERCENT;
                    n = n + 1;
                    esc_state = upd_pkg::PEND_NONE;
                    as_plain = 1'b1;
                end
            upd_pkg::PEND_DIGIT:
                if (hex_char(b))
                begin
                    outs[n] = {nibble_of(esc_digit), nibble_of(b)};
                    n = n + 1;
                    esc_state = upd_pkg::PEND_NONE;
                    esc_digit = 8'h00;
                end
                else
                begin
                    // Broken after one digit: release percent and digit, then decode b
                    outs[n] = upd_pkg::CH_PERCENT;
                    outs[n + 1] = esc_digit;
                    n = n + 2;
                    esc_state = upd_pkg::PEND_NONE;
                    esc_digit = 8'h00;
                    as_plain = 1'b1;
                end
            default:
            begin
                esc_state = upd_pkg::PEND_NONE;
                as_plain = 1'b1;
            end
        endcase

        if (as_plain)
        begin
            if (b == upd_pkg::CH_PLUS)
            begin
                outs[n] = upd_pkg::CH_SPACE;
                n = n + 1;
            end
            else if (b == upd_pkg::CH_PERCENT)
                esc_state = upd_pkg::PEND_PERCENT;
            else
            begin
                outs[n] = b;
                n = n + 1;
            end
        end

        // End of string: flush whatever escape is still open
        if (lst)
        begin
            if (esc_state == upd_pkg::PEND_PERCENT)
            begin
                outs[n] = upd_pkg::CH_PERCENT;
                n = n + 1;
            end
            else if (esc_state == upd_pkg::PEND_DIGIT)
            begin
                outs[n] = upd_pkg::CH_PERCENT;
                outs[n + 1] = esc_digit;
                n = n + 2;
            end
            esc_state = upd_pkg::PEND_NONE;
            esc_digit = 8'h00;
        end

        for (int i = 0; i < n; i++)
        begin
            d.data = outs[i];
            d.last = lst && (i == n - 1);
            decoded_q.push_back(d);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [8:0] got,
                                   input logic [8:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        errors = errors + 1;
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic lst, input logic drain);
        raw_byte_t r;
        r.data = b;
        r.last = lst;
        r.drain_first = drain;
        raw_q.push_back(r);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], i == s.len() - 1, 1'b0);
    endtask

    // Driver: present the next raw byte, hold it until taken, idle at random.
    always @(posedge clk)
    begin
        raw_byte_t nxt;
        logic      taken;
        logic      idle;
        logic      hold_back;
        if (!rst_n)
            rx.valid <= 1'b0;
        else
        begin
            taken = rx.valid && rx.ready;
            if (taken)
                decode_byte(rx.in_byte, rx.in_last);
            if (!rx.valid || taken)
            begin
                idle = !(cyc >= QUIET_FROM && cyc < QUIET_TO) && ($urandom_range(99) < 20);
                hold_back = raw_q.size() > 0 && raw_q[0].drain_first && (!drained || taken);
                if (raw_q.size() > 0 && !idle && !hold_back)
                begin
                    nxt = raw_q.pop_front();
                    rx.valid   <= 1'b1;
                    rx.in_byte <= nxt.data;
                    rx.in_last <= nxt.last;
                end
                else
                    rx.valid <= 1'b0;
            end
        end
    end

    // Monitor: check each decoded byte against the oldest expected one.
    always @(posedge clk)
    begin
        decoded_byte_t want;
        if (!rst_n)
            tx.ready <= 1'b0;
        else
        begin
            if (tx.valid && tx.ready)
            begin
                if (decoded_q.size() == 0)
                    report_mismatch("unexpected byte", {tx.out_last, tx.out_byte}, 9'h000);
                else
                begin
                    want = decoded_q.pop_front();
                    if (tx.out_byte !== want.data)
                        report_mismatch("out_byte", {1'b0, tx.out_byte}, {1'b0, want.data});
                    if (tx.out_last !== want.last)
                        report_mismatch("out_last", {8'h00, tx.out_last}, {8'h00, want.last});
                end
            end
            tx.ready <= (cyc >= QUIET_FROM && cyc < QUIET_TO) || ($urandom_range(99) >= 20);
        end
    end

    // Watchdog: end the run if traffic stops on both sides for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx.valid && rx.ready) || (tx.valid && tx.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] str[$];
        string      hex_set;
        int         tokens;
        int         r;
        logic       well_formed;
        logic       drain;
        logic       first_string;

        rst_n      = 1'b0;
        rx.valid   = 1'b0;
        rx.in_byte = 8'h00;
        rx.in_last = 1'b0;
        tx.ready   = 1'b0;
        hex_set    = "0123456789ABCDEFabcdef";

        // Directed strings: plus, mixed-case and extreme escapes, broken escapes,
        // a breaking percent that opens a new escape, and escapes cut by end of string.
        queue_text("+");
        queue_text("%Ff");
        queue_text("%a0");
        queue_byte(upd_pkg::CH_PERCENT, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(upd_pkg::CH_PERCENT, 1'b0, 1'b0);
        queue_byte("4", 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b1, 1'b0);
        queue_text("%4%41");
        queue_text("%");
        queue_text("%4");
        queue_text("%9+");

        // Random strings: mostly well-formed, some noise rich in percent signs and digits
        first_string = 1'b1;
        while (raw_q.size() < RAW_ITEMS)
        begin
            str.delete();
            tokens = $urandom_range(1, 12);
            well_formed = $urandom_range(99) < 80;
            drain = first_string || ($urandom_range(39) == 0);
            first_string = 1'b0;
            for (int t = 0; t < tokens; t++)
            begin
                r = $urandom_range(99);
                if (well_formed)
                begin
                    if (r < 30)
                    begin
                        str.push_back(upd_pkg::CH_PERCENT);
                        str.push_back(hex_set[$urandom_range(21)]);
                        str.push_back(hex_set[$urandom_range(21)]);
                    end
                    else if (r < 40)
                        str.push_back(upd_pkg::CH_PLUS);
                    else
                    begin
                        str.push_back(8'($urandom_range(255)));
                        if (str[$] == upd_pkg::CH_PERCENT)
                            str[$] = upd_pkg::CH_PLUS;
                    end
                end
                else
                begin
                    if (r < 25)
                        str.push_back(upd_pkg::CH_PERCENT);
                    else if (r < 55)
                        str.push_back(hex_set[$urandom_range(21)]);
                    else if (r < 65)
                        str.push_back(upd_pkg::CH_PLUS);
                    else
                        str.push_back(8'($urandom_range(255)));
                end
            end
            foreach (str[i])
                queue_byte(str[i], i == str.size() - 1, drain && i == 0);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the stimulus to go out and every decoded byte to come back
        do
            @(negedge clk);
        while (raw_q.size() != 0 || rx.valid || decoded_q.size() != 0);
        repeat (16) @(posedge clk);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/upd_pkg.sv
rtl/upd_if.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder_top.sv
test/tb_top.sv
